FILE: hw/rtl/r59dec_pkg.sv
// ----------------------------------------------------------------------------
// r59dec_pkg: R5900 opcode classifier package
// Instruction kind codes, numbered densely from 1; zero is unknown.
// ----------------------------------------------------------------------------
`default_nettype none

package r59dec_pkg;

	typedef enum logic [7:0] {
		K_UNKNOWN = 8'd0,
		K_QMFC2, K_QMTC2, K_CFC2, K_CTC2, K_VMADDA_BC, K_VADDA_BC, K_VMULA_BC, K_VMULA,
		K_VADDA, K_VMADDA, K_VMSUBA_BC, K_VFTOI0, K_VFTOI4, K_VFTOI12, K_VFTOI15,
		K_VITOF0, K_VITOF12, K_VITOF15, K_VMULAQ, K_VABS, K_VCLIP, K_VNOP, K_VSQI,
		K_VLQI, K_VWAITQ, K_VOPMULA, K_VMSUBA, K_VMOVE, K_VMR32, K_VDIV, K_VSQRT,
		K_VMTIR, K_VRSQRT, K_VRNEXT, K_VRGET, K_VRXOR, K_VADD_BC, K_VSUB_BC,
		K_VMADD_BC, K_VMSUB_BC, K_VMAX_BC, K_VMINI_BC, K_VMUL_BC, K_VMULQ, K_VADDQ,
		K_VSUBQ, K_VMSUBQ, K_VADD, K_VMADD, K_VMUL, K_VMAX, K_VSUB, K_VMSUB,
		K_VOPMSUB, K_VMINI, K_VIADDI, K_VIAND, K_VCALLMS,
		K_CVTSW,
		K_ADDS, K_SUBS, K_MULS, K_DIVS, K_ABSS, K_MOVS, K_NEGS, K_SQRTS, K_RSQRTS,
		K_ADDAS, K_MULAS, K_MADDS, K_MSUBS, K_MADDAS, K_MSUBAS, K_CVTWS, K_MAXS,
		K_MINS, K_CEQS, K_CLTS, K_CLES,
		K_BC1F, K_BC1T, K_BC1FL, K_BC1TL,
		K_MFC1, K_MTC1,
		K_ERET, K_EI,
		K_MTC0, K_MTDAB, K_MTDABM, K_MTPC,
		K_MFC0, K_MFPC,
		K_PINTEH, K_PCPYUD, K_POR, K_PNOR, K_PCPYH, K_PEXCW,
		K_PCPYLD, K_PMADDH, K_PAND, K_PXOR, K_PMULTH, K_PEXEW, K_PROT3W,
		K_PABSW, K_PCEQW, K_PMINW, K_PMINH, K_PCEQB, K_PEXTUW, K_PEXTUH, K_PEXTUB,
		K_QFSRV,
		K_PADDW, K_PSUBW, K_PCGTW, K_PMAXW, K_PADDH, K_PSUBH, K_PMAXH, K_PADDB,
		K_PCGTB, K_PEXTLW, K_PPACW, K_PPACH, K_PEXTLH, K_PEXTLB, K_PPACB,
		K_PMFHL_UW, K_PMFHL_LW, K_PMFHL_LH,
		K_PLZCW, K_MTLO1, K_MFLO1, K_PSLLH, K_PSRLH, K_PSRAH, K_PSLLW, K_PSRAW,
		K_BLTZ, K_BGEZ, K_BLTZL, K_BGEZL, K_BGEZAL, K_MTSAB,
		K_SYNCL, K_SYNCP,
		K_SLL, K_SRL, K_SRA, K_SLLV, K_JR, K_JALR, K_MOVZ, K_MOVN, K_SYSCALL,
		K_MFHI, K_MFLO, K_DSLLV, K_DSRLV, K_DSRAV, K_MULT3, K_MULTU3, K_DIV, K_DIVU,
		K_ADDU, K_SUBU, K_AND, K_OR, K_XOR, K_NOR, K_SLT, K_SLTU, K_DADDU, K_DSUBU,
		K_DSLL, K_DSRL, K_DSRA, K_DSLL32, K_DSRL32, K_DSRA32,
		K_CACHE_DXWBIN,
		K_BEQ, K_BNE, K_BLEZ, K_BGTZ, K_ADDIU, K_SLTI, K_SLTIU, K_ANDI, K_ORI,
		K_XORI, K_LUI, K_BEQL, K_BNEL, K_BGTZL, K_DADDIU, K_LDL, K_LDR, K_LQ, K_SQ,
		K_LB, K_LH, K_LWL, K_LW, K_LBU, K_LHU, K_LWR, K_LWU, K_SB, K_SH, K_SW,
		K_LWC1, K_PREF, K_LQC2, K_LD, K_SWC1, K_SQC2, K_SD
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  bad;
	} dec_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/r59dec_core.sv
// ----------------------------------------------------------------------------
// r59dec_core: instruction word decode tables
// Combinational nested decode of one word into a kind and a reserved-field flag.
// ----------------------------------------------------------------------------
`default_nettype none

module r59dec_core
	import r59dec_pkg::*;
(
	input  wire logic [31:0] word,
	output dec_res_t         res
);

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [3:0]  dest;
	logic [10:0] l11;
	logic        rs0, rt0, rd0, sa0, co, vnop_like, pc;

	assign op   = word[31:26];
	assign rs   = word[25:21];
	assign rt   = word[20:16];
	assign rd   = word[15:11];
	assign sa   = word[10:6];
	assign fn   = word[5:0];
	assign dest = word[24:21];
	assign l11  = word[10:0];
	assign rs0  = (rs == 5'd0);
	assign rt0  = (rt == 5'd0);
	assign rd0  = (rd == 5'd0);
	assign sa0  = (sa == 5'd0);
	assign co   = word[25];
	assign vnop_like = (dest == 4'd0) && rt0 && rd0;
	assign pc   = (rd == 5'h19) && sa0 && word[0];

	function automatic kind_t mmi_grp(input logic [1:0] g, input logic [4:0] s);
		kind_t k;
		k = K_UNKNOWN;
		unique case (g)
			2'd0: begin
				unique case (s)
					5'h00: k = K_PADDW;  5'h01: k = K_PSUBW;
					5'h02: k = K_PCGTW;  5'h03: k = K_PMAXW;
					5'h04: k = K_PADDH;  5'h05: k = K_PSUBH;
					5'h07: k = K_PMAXH;  5'h08: k = K_PADDB;
					5'h0a: k = K_PCGTB;  5'h12: k = K_PEXTLW;
					5'h13: k = K_PPACW;  5'h17: k = K_PPACH;
					5'h16: k = K_PEXTLH; 5'h1a: k = K_PEXTLB;
					5'h1b: k = K_PPACB;  default: k = K_UNKNOWN;
				endcase
			end
			2'd1: begin
				unique case (s)
					5'h01: k = K_PABSW;  5'h02: k = K_PCEQW;
					5'h03: k = K_PMINW;  5'h07: k = K_PMINH;
					5'h0a: k = K_PCEQB;  5'h12: k = K_PEXTUW;
					5'h16: k = K_PEXTUH; 5'h1a: k = K_PEXTUB;
					5'h1b: k = K_QFSRV;  default: k = K_UNKNOWN;
				endcase
			end
			2'd2: begin
				unique case (s)
					5'h0e: k = K_PCPYLD; 5'h10: k = K_PMADDH;
					5'h12: k = K_PAND;   5'h13: k = K_PXOR;
					5'h1c: k = K_PMULTH; 5'h1e: k = K_PEXEW;
					5'h1f: k = K_PROT3W; default: k = K_UNKNOWN;
				endcase
			end
			default: begin
				unique case (s)
					5'h0a: k = K_PINTEH; 5'h0e: k = K_PCPYUD;
					5'h12: k = K_POR;    5'h13: k = K_PNOR;
					5'h1b: k = K_PCPYH;  5'h1e: k = K_PEXCW;
					default: k = K_UNKNOWN;
				endcase
			end
		endcase
		return k;
	endfunction

	kind_t k;
	logic  bad;

	always_comb begin
		k   = K_UNKNOWN;
		bad = 1'b0;
		unique case (op)
			6'h00: begin
				unique case (fn)
					6'h00: begin k = K_SLL; bad = !rs0; end
					6'h02: begin k = K_SRL; bad = !rs0; end
					6'h03: begin k = K_SRA; bad = !rs0; end
					6'h04: begin k = K_SLLV; bad = !sa0; end
					6'h08: begin k = K_JR; bad = !(sa0 && rd0 && rt0); end
					6'h09: begin k = K_JALR; bad = !(rt0 && sa0); end
					6'h0a: begin k = K_MOVZ; bad = !sa0; end
					6'h0b: begin k = K_MOVN; bad = !sa0; end
					6'h0c: k = K_SYSCALL;
					6'h0f: begin
						bad = !(rt0 && rs0 && rd0);
						if (sa == 5'h00) k = K_SYNCL;
						else if (sa == 5'h10) k = K_SYNCP;
					end
					6'h10: begin k = K_MFHI; bad = !(rs0 && rt0 && sa0); end
					6'h12: begin k = K_MFLO; bad = !(rs0 && rt0 && sa0); end
					6'h14: begin k = K_DSLLV; bad = !sa0; end
					6'h16: begin k = K_DSRLV; bad = !sa0; end
					6'h17: begin k = K_DSRAV; bad = !sa0; end
					6'h18: begin k = K_MULT3; bad = !sa0; end
					6'h19: begin k = K_MULTU3; bad = !sa0; end
					6'h1a: begin k = K_DIV; bad = !(sa0 && rd0); end
					6'h1b: begin k = K_DIVU; bad = !(sa0 && rd0); end
					6'h21: begin k = K_ADDU; bad = !sa0; end
					6'h23: begin k = K_SUBU; bad = !sa0; end
					6'h24: begin k = K_AND; bad = !sa0; end
					6'h25: begin k = K_OR; bad = !sa0; end
					6'h26: begin k = K_XOR; bad = !sa0; end
					6'h27: begin k = K_NOR; bad = !sa0; end
					6'h2a: begin k = K_SLT; bad = !sa0; end
					6'h2b: begin k = K_SLTU; bad = !sa0; end
					6'h2d: k = K_DADDU;
					6'h2f: k = K_DSUBU;
					6'h38: begin k = K_DSLL; bad = !rs0; end
					6'h3a: begin k = K_DSRL; bad = !rs0; end
					6'h3b: begin k = K_DSRA; bad = !rs0; end
					6'h3c: begin k = K_DSLL32; bad = !rs0; end
					6'h3e: begin k = K_DSRL32; bad = !rs0; end
					6'h3f: begin k = K_DSRA32; bad = !rs0; end
					default: k = K_UNKNOWN;
				endcase
			end
			6'h01: begin
				unique case (rt)
					5'h00: k = K_BLTZ;
					5'h01: k = K_BGEZ;
					5'h02: k = K_BLTZL;
					5'h03: k = K_BGEZL;
					5'h11: k = K_BGEZAL;
					5'h18: k = K_MTSAB;
					default: k = K_UNKNOWN;
				endcase
			end
			6'h04: k = K_BEQ;
			6'h05: k = K_BNE;
			6'h06: k = K_BLEZ;
			6'h07: k = K_BGTZ;
			6'h09: k = K_ADDIU;
			6'h0a: k = K_SLTI;
			6'h0b: k = K_SLTIU;
			6'h0c: k = K_ANDI;
			6'h0d: k = K_ORI;
			6'h0e: k = K_XORI;
			6'h0f: begin k = K_LUI; bad = !rs0; end
			6'h10: begin
				unique case (rs)
					5'h00: begin
						if (l11 == 11'd0) k = K_MFC0;
						else if (pc) k = K_MFPC;
					end
					5'h04: begin
						if (l11 == 11'd0) k = K_MTC0;
						else if (l11 == 11'd4) begin k = K_MTDAB; bad = (rd != 5'h18); end
						else if (l11 == 11'd5) begin k = K_MTDABM; bad = (rd != 5'h18); end
						else if (pc) k = K_MTPC;
					end
					5'h10: begin
						if (fn == 6'h18) k = K_ERET;
						else if (fn == 6'h38) begin k = K_EI; bad = !(sa0 && rd0 && rt0); end
					end
					default: k = K_UNKNOWN;
				endcase
			end
			6'h11: begin
				unique case (rs)
					5'h00: begin k = K_MFC1; bad = !(sa0 && fn == 6'd0); end
					5'h04: begin k = K_MTC1; bad = !(sa0 && fn == 6'd0); end
					5'h08: begin
						if (rt < 5'd4) k = kind_t'(8'(K_BC1F) + {6'd0, rt[1:0]});
					end
					5'h10: begin
						unique case (fn)
							6'h00: k = K_ADDS;
							6'h01: k = K_SUBS;
							6'h02: k = K_MULS;
							6'h03: k = K_DIVS;
							6'h05: k = K_ABSS;
							6'h06: begin k = K_MOVS; bad = !rt0; end
							6'h07: begin k = K_NEGS; bad = !rt0; end
							6'h04: begin k = K_SQRTS; bad = !rd0; end
							6'h16: k = K_RSQRTS;
							6'h18: begin k = K_ADDAS; bad = !sa0; end
							6'h1a: begin k = K_MULAS; bad = !sa0; end
							6'h1c: k = K_MADDS;
							6'h1d: k = K_MSUBS;
							6'h1e: begin k = K_MADDAS; bad = !sa0; end
							6'h1f: begin k = K_MSUBAS; bad = !sa0; end
							6'h24: begin k = K_CVTWS; bad = !rt0; end
							6'h28: k = K_MAXS;
							6'h29: k = K_MINS;
							6'h32: begin k = K_CEQS; bad = !sa0; end
							6'h34: begin k = K_CLTS; bad = !sa0; end
							6'h36: begin k = K_CLES; bad = !sa0; end
							default: k = K_UNKNOWN;
						endcase
					end
					5'h14: begin
						if (fn == 6'h20) begin k = K_CVTSW; bad = !rt0; end
					end
					default: k = K_UNKNOWN;
				endcase
			end
			6'h12: begin
				if (l11 <= 11'd1) begin
					unique case (rs)
						5'd1: k = K_QMFC2;
						5'd5: begin k = K_QMTC2; bad = (word[10:1] != 10'd0); end
						5'd2: k = K_CFC2;
						5'd6: k = K_CTC2;
						default: k = K_UNKNOWN;
					endcase
				end else begin
					unique case (l11)
						11'h0bc, 11'h0bd, 11'h0be, 11'h0bf: k = K_VMADDA_BC;
						11'h03c, 11'h03d, 11'h03e, 11'h03f: k = K_VADDA_BC;
						11'h1bc, 11'h1bd, 11'h1be, 11'h1bf: k = K_VMULA_BC;
						11'h2be: k = K_VMULA;
						11'h2bc: k = K_VADDA;
						11'h2bd: k = K_VMADDA;
						11'h0fc, 11'h0fd, 11'h0fe, 11'h0ff: k = K_VMSUBA_BC;
						11'h17c: k = K_VFTOI0;
						11'h17d: k = K_VFTOI4;
						11'h17e: k = K_VFTOI12;
						11'h17f: k = K_VFTOI15;
						11'h13c: k = K_VITOF0;
						11'h13e: k = K_VITOF12;
						11'h13f: k = K_VITOF15;
						11'h1fc: begin k = K_VMULAQ; bad = !rt0; end
						11'h1fd: k = K_VABS;
						11'h1ff: begin k = K_VCLIP; bad = (dest != 4'he); end
						11'h2ff: k = K_VNOP;
						11'h37d: k = K_VSQI;
						11'h37c: k = K_VLQI;
						11'h3bf: k = K_VWAITQ;
						11'h2fe: begin k = K_VOPMULA; bad = (dest != 4'he); end
						11'h2fd: k = K_VMSUBA;
						11'h33c: k = K_VMOVE;
						11'h33d: k = K_VMR32;
						11'h3bc: k = K_VDIV;
						11'h3bd: begin k = K_VSQRT; bad = !(rd0 && word[22:21] == 2'd0); end
						11'h3fc: begin k = K_VMTIR; bad = (word[24:23] != 2'd0); end
						11'h3be: k = K_VRSQRT;
						11'h43c: begin k = K_VRNEXT; bad = !rd0; end
						11'h43d: begin k = K_VRGET; bad = !rd0; end
						11'h43f: begin k = K_VRXOR; bad = !(rt0 && word[24:23] == 2'd0); end
						default: begin
							if (fn < 6'd28) begin
								k = kind_t'(8'(K_VADD_BC) + {4'd0, fn[4:2]});
							end else begin
								unique case (fn)
									6'h1c: begin k = K_VMULQ; bad = !rt0; end
									6'h20: k = K_VADDQ;
									6'h24: k = K_VSUBQ;
									6'h25: begin k = K_VMSUBQ; bad = !rt0; end
									6'h28: k = K_VADD;
									6'h29: k = K_VMADD;
									6'h2a: k = K_VMUL;
									6'h2b: k = K_VMAX;
									6'h2c: k = K_VSUB;
									6'h2d: k = K_VMSUB;
									6'h2e: begin k = K_VOPMSUB; bad = (dest != 4'he); end
									6'h2f: k = K_VMINI;
									6'h32: begin k = K_VIADDI; bad = (dest != 4'd0); end
									6'h34: begin k = K_VIAND; bad = (dest != 4'd0); end
									6'h38: begin k = K_VCALLMS; bad = (dest != 4'd0); end
									default: k = K_UNKNOWN;
								endcase
							end
						end
					endcase
					// vnop-like checks; co bit required except VNOP, VWAITQ, VMSUBA, VMR32
					if (l11 == 11'h2ff || l11 == 11'h3bf) bad = !vnop_like;
					else if (l11 != 11'h2fd && l11 != 11'h33d && k != K_UNKNOWN)
						bad = bad || !co;
				end
			end
			6'h14: k = K_BEQL;
			6'h15: k = K_BNEL;
			6'h17: begin k = K_BGTZL; bad = !rt0; end
			6'h19: k = K_DADDIU;
			6'h1a: k = K_LDL;
			6'h1b: k = K_LDR;
			6'h1c: begin
				unique case (fn)
					6'h04: begin k = K_PLZCW; bad = !(sa0 && rt0); end
					6'h08: k = mmi_grp(2'd0, sa);
					6'h09: k = mmi_grp(2'd2, sa);
					6'h13: begin k = K_MTLO1; bad = !(sa0 && rd0 && rt0); end
					6'h12: begin k = K_MFLO1; bad = !(sa0 && rs0 && rt0); end
					6'h28: k = mmi_grp(2'd1, sa);
					6'h29: begin
						k = mmi_grp(2'd3, sa);
						bad = (k == K_PCPYH) && !rs0;
					end
					6'h30: begin
						if (sa == 5'd1) k = K_PMFHL_UW;
						else if (sa == 5'd0) k = K_PMFHL_LW;
						else if (sa == 5'd3) k = K_PMFHL_LH;
						bad = (k != K_UNKNOWN) && !(rs0 && rt0);
					end
					6'h34: k = K_PSLLH;
					6'h36: k = K_PSRLH;
					6'h37: k = K_PSRAH;
					6'h3c: k = K_PSLLW;
					6'h3f: k = K_PSRAW;
					default: k = K_UNKNOWN;
				endcase
			end
			6'h1e: k = K_LQ;
			6'h1f: k = K_SQ;
			6'h20: k = K_LB;
			6'h21: k = K_LH;
			6'h22: k = K_LWL;
			6'h23: k = K_LW;
			6'h24: k = K_LBU;
			6'h25: k = K_LHU;
			6'h26: k = K_LWR;
			6'h27: k = K_LWU;
			6'h28: k = K_SB;
			6'h29: k = K_SH;
			6'h2b: k = K_SW;
			6'h2f: begin
				if (rt == 5'h14) k = K_CACHE_DXWBIN;
			end
			6'h31: k = K_LWC1;
			6'h33: k = K_PREF;
			6'h36: k = K_LQC2;
			6'h37: k = K_LD;
			6'h39: k = K_SWC1;
			6'h3e: k = K_SQC2;
			6'h3f: k = K_SD;
			default: k = K_UNKNOWN;
		endcase
	end

	assign res.kind = k;
	assign res.bad  = bad;

endmodule

`default_nettype wire

FILE: hw/rtl/r5900_opcode_classifier_top.sv
// ----------------------------------------------------------------------------
// r5900_opcode_classifier_top: R5900 instruction word classifier
// Stages: input register, then result register; the decode table sits between them.
// Throughput: one item per cycle while out_stall is low.
// Reset clears the valid flags of both stages; payload registers hold.
// ----------------------------------------------------------------------------
`default_nettype none

module r5900_opcode_classifier_top
	import r59dec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [31:0] instruction_word,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  instruction_kind,
	output      logic        is_unknown,
	output      logic        reserved_field_error
);

	logic        vld_s1, vld_s2;
	logic [31:0] word_s1;
	dec_res_t    dec, res_s2;
	logic        adv_s2, adv_s1;

	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	r59dec_core u_core (
		.word (word_s1),
		.res  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) word_s1 <= instruction_word;
		if (adv_s2 && vld_s1) res_s2 <= dec;
	end

	assign out_valid            = vld_s2;
	assign instruction_kind     = res_s2.kind;
	assign is_unknown           = (res_s2.kind == K_UNKNOWN);
	assign reserved_field_error = res_s2.bad;

endmodule

`default_nettype wire

FILE: hw/rtl/r59dec_checker.sv
// ----------------------------------------------------------------------------
// r59dec_checker: port checks for the classifier
// Watches handshake and result consistency at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module r59dec_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] instruction_kind,
	input wire logic       is_unknown,
	input wire logic       reserved_field_error
);

	a_unk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_unknown == (instruction_kind == 8'd0)))
		else $error("is_unknown mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(instruction_kind)
			&& $stable(reserved_field_error))
		else $error("stalled item changed");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted item not delivered");

	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind r5900_opcode_classifier_top r59dec_checker u_chk (.*);

`default_nettype wire
